### hw/rtl/gcdist_pkg.sv
package gcdist_pkg;

    localparam int FRAC_BITS     = 22;
    localparam int CORDIC_ITERS  = 30;
    localparam int SQRT_STEPS    = 31;
    localparam int DEG_DIV       = 45;
    localparam int FRAC_SHIFT    = 29 - FRAC_BITS;
    localparam int NUM_LANES     = 4;

    localparam logic signed [33:0] LIM90  = 34'sd90 <<< FRAC_BITS;
    localparam logic signed [33:0] LIM360 = 34'sd360 <<< FRAC_BITS;
    localparam logic signed [33:0] FULL   = 34'sd360 <<< FRAC_BITS;

    localparam logic [31:0] RECIP_K = 32'((64'd1 << 37) / DEG_DIV);

    localparam logic signed [33:0] GAIN_Q30     = 34'sh026DD3B6A;
    localparam logic signed [34:0] ONE_Q30      = 35'sd1 <<< 30;
    localparam logic [30:0]        PI_Q29       = 31'h6487ED51;
    localparam logic [32:0]        DIST_MAX     = 33'd2513274123;
    localparam logic [22:0]        RADIUS_RESET = 23'd6378137;
    localparam logic [8:0]         CM_PER_M4    = 9'd400;

    typedef logic signed [33:0] cv_t;
    typedef logic signed [32:0] az_t;
    typedef logic [30:0]        ang_t;
    typedef logic [25:0]        quo_t;
    typedef logic [5:0]         rem_t;
    typedef logic [62:0]        sq_t;
    typedef logic signed [35:0] prod_t;
    typedef logic [FRAC_SHIFT:0] frac_t;
    typedef frac_t frac_tab_t [DEG_DIV];

    localparam logic [29:0] ATAN_TURNS [CORDIC_ITERS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    function automatic frac_tab_t make_frac_tab();
        frac_tab_t t;
        for (int r = 0; r < DEG_DIV; r++)
        begin
            t[r] = frac_t'((r << FRAC_SHIFT) / DEG_DIV);
        end
        return t;
    endfunction

    localparam frac_tab_t FRAC_TAB = make_frac_tab();

    // floor modulo one full turn; operand within two turns either side
    function automatic ang_t mod_full(input logic signed [33:0] d);
        logic signed [35:0] c [5];
        ang_t res;
        c[0] = 36'(d);
        c[1] = 36'(d) - 36'(FULL);
        c[2] = 36'(d) - 36'(FULL) - 36'(FULL);
        c[3] = 36'(d) + 36'(FULL);
        c[4] = 36'(d) + 36'(FULL) + 36'(FULL);
        res = '0;
        for (int k = 0; k < 5; k++)
        begin
            if (c[k] >= 0 && c[k] < 36'(FULL))
            begin
                res = ang_t'(c[k]);
            end
        end
        return res;
    endfunction

endpackage

### hw/rtl/great_circle_distance.sv
// Haversine great-circle distance, fully pipelined.
//
// Request channel: in_valid / in_stall with two points, latitude and
// longitude in signed degrees times 2^22. A request is taken at a rising
// edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall with distance_cm and in_range.
// Coordinates beyond +-90 (lat) or +-360 (lon) degrees give in_range 0 and
// distance 0.
// The radius register (reset 6378137 m) is written through cfg_write_en /
// cfg_write_data; the user must do so only while the pipeline is empty, as
// the block does not enforce it. One request per cycle is taken unless
// out_stall holds the pipeline. Depth: the 30-stage rotation CORDIC (four
// lanes side by side), 31-stage square-root array, 30-stage vectoring CORDIC.
// Reset empties the pipeline (all valid bits cleared). While out_valid is
// high and out_stall is high the whole pipeline holds and in_stall is
// raised; nothing is dropped or repeated.
module great_circle_distance (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [29:0]  first_lat,
    input  logic signed [31:0]  first_lon,
    input  logic signed [29:0]  second_lat,
    input  logic signed [31:0]  second_lon,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         distance_cm,
    output logic                in_range,
    input  logic                cfg_write_en,
    input  logic [22:0]         cfg_write_data
);

    localparam int NSTG = 105;
    localparam int CI   = gcdist_pkg::CORDIC_ITERS;
    localparam int SS   = gcdist_pkg::SQRT_STEPS;
    localparam int NL   = gcdist_pkg::NUM_LANES;

    logic                adv;
    logic [NSTG-1:0]     vld_reg;
    logic [NSTG-1:1]     ok_reg;
    logic                ok_next;
    logic [22:0]         radius_reg;

    logic signed [29:0]  lat1_reg, lat2_reg;
    logic signed [31:0]  lon1_reg, lon2_reg;

    gcdist_pkg::ang_t    m2_reg [NL];
    gcdist_pkg::ang_t    m2_next [NL];
    gcdist_pkg::ang_t    m3_reg [NL];
    gcdist_pkg::quo_t    q3_reg [NL];
    gcdist_pkg::quo_t    q3_next [NL];
    gcdist_pkg::quo_t    q4_reg [NL];
    gcdist_pkg::quo_t    q4_next [NL];
    gcdist_pkg::rem_t    r4_reg [NL];
    gcdist_pkg::rem_t    r4_next [NL];

    gcdist_pkg::cv_t     cx_reg [NL][CI+1];
    gcdist_pkg::cv_t     cy_reg [NL][CI+1];
    gcdist_pkg::az_t     cz_reg [NL][CI+1];
    logic [1:0]          cq_reg [NL][CI+1];
    gcdist_pkg::cv_t     cx_next [NL][CI+1];
    gcdist_pkg::cv_t     cy_next [NL][CI+1];
    gcdist_pkg::az_t     cz_next [NL][CI+1];
    logic [1:0]          cq_next [NL][CI+1];

    gcdist_pkg::cv_t     cos_reg [NL];
    gcdist_pkg::cv_t     cos_next [NL];

    logic [30:0]         hphi_reg, hlam_reg, hphi5_reg;
    logic [30:0]         hphi_next, hlam_next;
    gcdist_pkg::prod_t   cc_reg, cc_next;
    gcdist_pkg::prod_t   p_reg, p_next;

    gcdist_pkg::sq_t     sn_reg [2][SS+1];
    gcdist_pkg::sq_t     sr_reg [2][SS+1];
    gcdist_pkg::sq_t     sn_next [2][SS+1];
    gcdist_pkg::sq_t     sr_next [2][SS+1];

    gcdist_pkg::cv_t     vx_reg [CI+1];
    gcdist_pkg::cv_t     vy_reg [CI+1];
    gcdist_pkg::az_t     vz_reg [CI+1];
    gcdist_pkg::cv_t     vx_next [CI+1];
    gcdist_pkg::cv_t     vy_next [CI+1];
    gcdist_pkg::az_t     vz_next [CI+1];

    logic [30:0]         zc_reg, zc_next;
    logic [31:0]         zpi_reg, zpi_next;
    logic [31:0]         r400_reg, r400_next;
    logic [63:0]         prod_reg, prod_next;
    logic [31:0]         dist_reg, dist_next;

    assign adv       = !(vld_reg[NSTG-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[NSTG-1];
    assign in_range  = ok_reg[NSTG-1];
    assign distance_cm = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= gcdist_pkg::RADIUS_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[NSTG-2:0], in_valid};
            end
            if (cfg_write_en)
            begin
                radius_reg <= cfg_write_data;
            end
        end
    end

    // range check, differences, reduction to one turn
    always_comb
    begin
        logic signed [33:0] la1, la2, lo1, lo2;
        la1 = 34'(lat1_reg);
        la2 = 34'(lat2_reg);
        lo1 = 34'(lon1_reg);
        lo2 = 34'(lon2_reg);
        ok_next = (la1 <= gcdist_pkg::LIM90) && (la1 >= -gcdist_pkg::LIM90)
               && (la2 <= gcdist_pkg::LIM90) && (la2 >= -gcdist_pkg::LIM90)
               && (lo1 <= gcdist_pkg::LIM360) && (lo1 >= -gcdist_pkg::LIM360)
               && (lo2 <= gcdist_pkg::LIM360) && (lo2 >= -gcdist_pkg::LIM360);
        m2_next[0] = gcdist_pkg::mod_full(la2 - la1);
        m2_next[1] = gcdist_pkg::mod_full(lo2 - lo1);
        m2_next[2] = gcdist_pkg::mod_full(la1);
        m2_next[3] = gcdist_pkg::mod_full(la2);
    end

    // degrees to binary angle: floor(m * 2^(29-F) / 45)
    always_comb
    begin
        logic [62:0] pk;
        logic [31:0] q45;
        logic [30:0] rr;
        for (int l = 0; l < NL; l++)
        begin
            pk = 63'(m2_reg[l]) * 63'(gcdist_pkg::RECIP_K);
            q3_next[l] = gcdist_pkg::quo_t'(pk >> 37);
            q45 = 32'(q3_reg[l]) * 32'(gcdist_pkg::DEG_DIV);
            rr = m3_reg[l] - q45[30:0];
            if (rr[6:0] >= 7'(gcdist_pkg::DEG_DIV))
            begin
                q4_next[l] = q3_reg[l] + 26'd1;
                r4_next[l] = 6'(rr[6:0] - 7'(gcdist_pkg::DEG_DIV));
            end
            else
            begin
                q4_next[l] = q3_reg[l];
                r4_next[l] = rr[5:0];
            end
        end
    end

    // rotation CORDIC for the four cosines
    always_comb
    begin
        logic [31:0] b;
        for (int l = 0; l < NL; l++)
        begin
            b = (32'(q4_reg[l]) << gcdist_pkg::FRAC_SHIFT)
              + 32'(gcdist_pkg::FRAC_TAB[r4_reg[l]]);
            cx_next[l][0] = gcdist_pkg::GAIN_Q30;
            cy_next[l][0] = '0;
            cz_next[l][0] = 33'(b[29:0]);
            cq_next[l][0] = b[31:30];
            for (int i = 0; i < CI; i++)
            begin
                cq_next[l][i+1] = cq_reg[l][i];
                if (cz_reg[l][i] >= 0)
                begin
                    cx_next[l][i+1] = cx_reg[l][i] - (cy_reg[l][i] >>> i);
                    cy_next[l][i+1] = cy_reg[l][i] + (cx_reg[l][i] >>> i);
                    cz_next[l][i+1] = cz_reg[l][i] - 33'(gcdist_pkg::ATAN_TURNS[i]);
                end
                else
                begin
                    cx_next[l][i+1] = cx_reg[l][i] + (cy_reg[l][i] >>> i);
                    cy_next[l][i+1] = cy_reg[l][i] - (cx_reg[l][i] >>> i);
                    cz_next[l][i+1] = cz_reg[l][i] + 33'(gcdist_pkg::ATAN_TURNS[i]);
                end
            end
            case (cq_reg[l][CI])
                2'd0:    cos_next[l] = cx_reg[l][CI];
                2'd1:    cos_next[l] = -cy_reg[l][CI];
                2'd2:    cos_next[l] = -cx_reg[l][CI];
                default: cos_next[l] = cy_reg[l][CI];
            endcase
        end
    end

    function automatic logic [30:0] half_term(input gcdist_pkg::cv_t c);
        logic signed [34:0] t;
        t = (gcdist_pkg::ONE_Q30 - 35'(c)) >>> 1;
        if (t < 0)
        begin
            return '0;
        end
        else if (t > gcdist_pkg::ONE_Q30)
        begin
            return 31'(gcdist_pkg::ONE_Q30);
        end
        return t[30:0];
    endfunction

    // haversine term
    always_comb
    begin
        logic signed [67:0] pc;
        logic signed [67:0] pp;
        logic signed [36:0] s;
        logic [30:0]        a;
        hphi_next = half_term(cos_reg[0]);
        hlam_next = half_term(cos_reg[1]);
        pc = 68'(cos_reg[2]) * 68'(cos_reg[3]);
        cc_next = gcdist_pkg::prod_t'(pc >>> 30);
        pp = 68'(cc_reg) * 68'($signed({1'b0, hlam_reg}));
        p_next = gcdist_pkg::prod_t'(pp >>> 30);
        s = 37'($signed({1'b0, hphi5_reg})) + 37'(p_reg);
        if (s < 0)
        begin
            a = '0;
        end
        else if (s > 37'(gcdist_pkg::ONE_Q30))
        begin
            a = 31'(gcdist_pkg::ONE_Q30);
        end
        else
        begin
            a = s[30:0];
        end
        sn_next[0][0] = 63'(31'(gcdist_pkg::ONE_Q30) - a) << 30;
        sn_next[1][0] = 63'(a) << 30;
        sr_next[0][0] = '0;
        sr_next[1][0] = '0;
    end

    // square roots, one result bit per stage
    always_comb
    begin
        gcdist_pkg::sq_t bitv;
        gcdist_pkg::sq_t t;
        for (int j = 0; j < 2; j++)
        begin
            for (int k = 0; k < SS; k++)
            begin
                bitv = 63'd1 << (60 - 2 * k);
                t = sr_reg[j][k] + bitv;
                if (sn_reg[j][k] >= t)
                begin
                    sn_next[j][k+1] = sn_reg[j][k] - t;
                    sr_next[j][k+1] = (sr_reg[j][k] >> 1) + bitv;
                end
                else
                begin
                    sn_next[j][k+1] = sn_reg[j][k];
                    sr_next[j][k+1] = sr_reg[j][k] >> 1;
                end
            end
        end
    end

    // vectoring CORDIC for the half central angle
    always_comb
    begin
        vx_next[0] = gcdist_pkg::cv_t'(sr_reg[0][SS]);
        vy_next[0] = gcdist_pkg::cv_t'(sr_reg[1][SS]);
        vz_next[0] = '0;
        for (int i = 0; i < CI; i++)
        begin
            if (vy_reg[i] > 0)
            begin
                vx_next[i+1] = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] - (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] + 33'(gcdist_pkg::ATAN_TURNS[i]);
            end
            else
            begin
                vx_next[i+1] = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] + (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] - 33'(gcdist_pkg::ATAN_TURNS[i]);
            end
        end
    end

    // scale to centimetres
    always_comb
    begin
        logic [61:0] zp;
        logic [64:0] rs;
        if (vz_reg[CI] < 0)
        begin
            zc_next = '0;
        end
        else if (vz_reg[CI] > 33'(gcdist_pkg::ONE_Q30))
        begin
            zc_next = 31'(gcdist_pkg::ONE_Q30);
        end
        else
        begin
            zc_next = vz_reg[CI][30:0];
        end
        zp = 62'(zc_reg) * 62'(gcdist_pkg::PI_Q29);
        zpi_next = zp[60:29];
        r400_next = 32'(radius_reg) * 32'(gcdist_pkg::CM_PER_M4);
        prod_next = 64'(r400_reg) * 64'(zpi_reg);
        rs = 65'(prod_reg) + (65'd1 << 31);
        if (!ok_reg[NSTG-2])
        begin
            dist_next = '0;
        end
        else if (rs[64:32] > gcdist_pkg::DIST_MAX)
        begin
            dist_next = gcdist_pkg::DIST_MAX[31:0];
        end
        else
        begin
            dist_next = rs[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat1_reg <= first_lat;
            lon1_reg <= first_lon;
            lat2_reg <= second_lat;
            lon2_reg <= second_lon;
            ok_reg   <= {ok_reg[NSTG-2:1], ok_next};
            for (int l = 0; l < NL; l++)
            begin
                m2_reg[l]  <= m2_next[l];
                m3_reg[l]  <= m2_reg[l];
                q3_reg[l]  <= q3_next[l];
                q4_reg[l]  <= q4_next[l];
                r4_reg[l]  <= r4_next[l];
                cos_reg[l] <= cos_next[l];
                for (int i = 0; i <= CI; i++)
                begin
                    cx_reg[l][i] <= cx_next[l][i];
                    cy_reg[l][i] <= cy_next[l][i];
                    cz_reg[l][i] <= cz_next[l][i];
                    cq_reg[l][i] <= cq_next[l][i];
                end
            end
            hphi_reg  <= hphi_next;
            hlam_reg  <= hlam_next;
            hphi5_reg <= hphi_reg;
            cc_reg    <= cc_next;
            p_reg     <= p_next;
            for (int j = 0; j < 2; j++)
            begin
                for (int k = 0; k <= SS; k++)
                begin
                    sn_reg[j][k] <= sn_next[j][k];
                    sr_reg[j][k] <= sr_next[j][k];
                end
            end
            for (int i = 0; i <= CI; i++)
            begin
                vx_reg[i] <= vx_next[i];
                vy_reg[i] <= vy_next[i];
                vz_reg[i] <= vz_next[i];
            end
            zc_reg   <= zc_next;
            zpi_reg  <= zpi_next;
            r400_reg <= r400_next;
            prod_reg <= prod_next;
            dist_reg <= dist_next;
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(dist_reg))
        else $error("pipeline moved while stalled");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> radius_reg == $past(cfg_write_data))
        else $error("radius write lost");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, distance_cm} <= gcdist_pkg::DIST_MAX)
        else $error("distance above saturation limit");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_range) |-> distance_cm == 32'd0)
        else $error("out-of-range request gave nonzero distance");

endmodule

### tb/sv/great_circle_distance_test.sv
`timescale 1ns / 100ps

module great_circle_distance_test;

    localparam int LATENCY   = 104;
    localparam int N_RANDOM  = 800;
    localparam longint Q30   = 64'sd1 << 30;
    localparam longint DMAX  = 64'd2513274123;
    localparam longint L90   = 64'sd90 << 22;
    localparam longint L360  = 64'sd360 << 22;
    localparam longint FULLD = 64'sd360 << 22;

    typedef struct {
        logic signed [29:0] lat1;
        logic signed [31:0] lon1;
        logic signed [29:0] lat2;
        logic signed [31:0] lon2;
        bit                 known;
        logic [31:0]        cm;
        logic               ok;
    } pair_t;

    typedef struct {
        logic [31:0] cm;
        logic        ok;
    } dist_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [29:0] first_lat;
    logic signed [31:0] first_lon;
    logic signed [29:0] second_lat;
    logic signed [31:0] second_lon;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        distance_cm;
    logic               in_range;
    logic               cfg_write_en;
    logic [22:0]        cfg_write_data;

    logic [22:0] radius;
    dist_t       pending[$];
    int          errors;
    bit          stall_free;

    great_circle_distance DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_lat(first_lat), .first_lon(first_lon),
        .second_lat(second_lat), .second_lon(second_lon),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance_cm(distance_cm), .in_range(in_range),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #20ms;
        $display("great_circle_distance_test: errors");
        $finish;
    end

    function automatic longint shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint cosine_q30(longint deg);
        longint m, x, y, z, nx, ny;
        longint unsigned b;
        int q;
        m = deg % FULLD;
        if (m < 0)
            m += FULLD;
        b = (longint'(m) << 32) / FULLD;
        q = int'((b >> 30) & 3);
        z = longint'(b & 64'h3FFFFFFF);
        x = 64'sh26DD3B6A;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - shr(y, i);
                ny = y + shr(x, i);
                z -= longint'(gcdist_pkg::ATAN_TURNS[i]);
            end
            else
            begin
                nx = x + shr(y, i);
                ny = y - shr(x, i);
                z += longint'(gcdist_pkg::ATAN_TURNS[i]);
            end
            x = nx;
            y = ny;
        end
        case (q)
            0: return x;
            1: return -y;
            2: return -x;
            default: return y;
        endcase
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic dist_t predict_distance(pair_t p);
        dist_t r;
        longint la1, lo1, la2, lo2, hphi, hlam, cc, a, x, y, z, nx, ny;
        longint unsigned zpi, d;
        la1 = p.lat1;
        lo1 = p.lon1;
        la2 = p.lat2;
        lo2 = p.lon2;
        r.cm = '0;
        r.ok = 1'b0;
        if (la1 > L90 || la1 < -L90 || la2 > L90 || la2 < -L90 ||
            lo1 > L360 || lo1 < -L360 || lo2 > L360 || lo2 < -L360)
            return r;
        hphi = clip(shr(Q30 - cosine_q30(la2 - la1), 1), 0, Q30);
        hlam = clip(shr(Q30 - cosine_q30(lo2 - lo1), 1), 0, Q30);
        cc = shr(cosine_q30(la1) * cosine_q30(la2), 30);
        a = clip(hphi + shr(cc * hlam, 30), 0, Q30);
        x = longint'(floor_sqrt(longint'(Q30 - a) << 30));
        y = longint'(floor_sqrt(longint'(a) << 30));
        z = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (y > 0)
            begin
                nx = x + shr(y, i);
                ny = y - shr(x, i);
                z += longint'(gcdist_pkg::ATAN_TURNS[i]);
            end
            else
            begin
                nx = x - shr(y, i);
                ny = y + shr(x, i);
                z -= longint'(gcdist_pkg::ATAN_TURNS[i]);
            end
            x = nx;
            y = ny;
        end
        z = clip(z, 0, Q30);
        zpi = (longint'(z) * 64'h6487ED51) >> 29;
        d = (longint'(radius) * 400 * zpi + (64'd1 << 31)) >> 32;
        if (d > DMAX)
            d = DMAX;
        r.cm = d[31:0];
        r.ok = 1'b1;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result side: stall pattern and checking
    initial
    begin
        int mode;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending.size() == 0)
                    report("unexpected result", distance_cm, 32'd0);
                else
                begin
                    dist_t e;
                    e = pending.pop_front();
                    if (distance_cm !== e.cm)
                        report("distance_cm", distance_cm, e.cm);
                    if (in_range !== e.ok)
                        report("in_range", 32'(in_range), 32'(e.ok));
                end
            end
            mode = int'(($time / 64'd2000) % 64'd3);
            if (stall_free || mode == 0)
                out_stall <= 1'b0;
            else if (mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    task automatic send(pair_t p);
        dist_t e;
        in_valid   <= 1'b1;
        first_lat  <= p.lat1;
        first_lon  <= p.lon1;
        second_lat <= p.lat2;
        second_lon <= p.lon2;
        e = predict_distance(p);
        if (p.known && (e.cm !== p.cm || e.ok !== p.ok))
            report("table entry", e.cm, p.cm);
        if (p.known)
        begin
            e.cm = p.cm;
            e.ok = p.ok;
        end
        do
            @(posedge clk);
        while (in_stall);
        pending.push_back(e);
    endtask

    task automatic idle(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_radius(logic [22:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        radius = v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [29:0] rand_lat(bit wild);
        if (wild)
            return 30'($urandom);
        return 30'(longint'($urandom_range(0, 32'd754974720)) - 64'sd377487360);
    endfunction

    function automatic logic signed [31:0] rand_lon(bit wild);
        if (wild)
            return 32'($urandom);
        return 32'(longint'($urandom_range(0, 32'd3019898880)) - 64'sd1509949440);
    endfunction

    pair_t table_rows [16];

    initial
    begin
        pair_t p;
        int burst, n;
        bit paused;
        logic [22:0] radii[5];
        errors = 0;
        stall_free = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        first_lat = '0;
        first_lon = '0;
        second_lat = '0;
        second_lon = '0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        radius = 23'd6378137;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lat1, lon1, lat2, lon2, known, cm, ok
        table_rows = '{
            '{0, 0, 0, 0, 0, 0, 0},
            '{30'sd377487360, 0, -30'sd377487360, 0, 0, 0, 0},
            '{30'sd377487361, 0, 0, 0, 1, 0, 0},
            '{0, 0, -30'sd377487361, 0, 1, 0, 0},
            '{0, 32'sd1509949441, 0, 0, 1, 0, 0},
            '{0, 0, 0, -32'sd1509949441, 1, 0, 0},
            '{30'h1FFFFFFF, 0, 0, 0, 1, 0, 0},
            '{30'h20000000, 0, 0, 0, 1, 0, 0},
            '{0, 32'h7FFFFFFF, 0, 32'h80000000, 1, 0, 0},
            '{0, 32'sd1509949440, 0, -32'sd1509949440, 0, 0, 0},
            '{0, 0, 0, 32'sd754974720, 0, 0, 0},
            '{0, 32'sd754974720, 0, -32'sd754974720, 0, 0, 0},
            '{30'sd377487360, 0, 30'sd377487360, 32'sd754974720, 0, 0, 0},
            '{30'sd188743680, 32'sd41943040, -30'sd4194304, 32'sd1, 0, 0, 0},
            '{-30'sd1, -32'sd1, 30'sd1, 32'sd1, 0, 0, 0},
            '{30'sd377487360, 32'sd1509949440, -30'sd377487360,
              -32'sd1509949440, 0, 0, 0}
        };
        foreach (table_rows[i])
            send(table_rows[i]);
        drain();

        radii = '{23'd8000000, 23'd1, 23'd0, 23'h7FFFFF, 23'd6378137};
        foreach (radii[r])
        begin
            set_radius(radii[r]);
            foreach (table_rows[i])
            begin
                p = table_rows[i];
                p.known = 1'b0;
                send(p);
            end
            n = 0;
            paused = 1'b0;
            while (n < N_RANDOM / 5)
            begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && n < N_RANDOM / 5; k++)
                begin
                    bit wild;
                    wild = ($urandom_range(0, 9) == 0);
                    p.lat1 = rand_lat(wild);
                    p.lon1 = rand_lon(wild);
                    p.lat2 = rand_lat(wild);
                    p.lon2 = rand_lon(wild);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        p.lat2 = p.lat1;
                        p.lon2 = p.lon1;
                    end
                    p.known = 1'b0;
                    send(p);
                    n++;
                end
                if (!paused && n >= N_RANDOM / 10)
                begin
                    paused = 1'b1;
                    in_valid <= 1'b0;
                    stall_free = 1'b1;
                    wait (pending.size() == 0);
                    stall_free = 1'b0;
                    @(posedge clk);
                end
                else if ($urandom_range(0, 2) != 0)
                    idle($urandom_range(1, 12));
            end
            drain();
        end

        if (errors == 0)
            $display("great_circle_distance_test: clean");
        else
            $display("great_circle_distance_test: errors");
        $finish;
    end
endmodule
